[hw/rtl/cpf_pkg.sv]
// Package: shared types and constants of the checksummed packet framer.
package cpf_pkg;

    localparam int ID_W       = 4;
    localparam int BYTE_W     = 8;
    localparam int TAG_W      = 4;

    localparam logic [BYTE_W-1:0] MAX_PAYLOAD = 8'd64;
    localparam logic [TAG_W-1:0]  TAG_RESET   = 4'd10;
    localparam logic [ID_W-1:0]   ID_INVALID  = 4'd0;

    // What the front part tells the back part to emit for one request.
    typedef enum logic [1:0] {
        CMD_ERROR,
        CMD_START,
        CMD_MID
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic              has_sum;
        logic [BYTE_W-1:0] header;
        logic [BYTE_W-1:0] len;
        logic [BYTE_W-1:0] data;
        logic [BYTE_W-1:0] sum;
    } cmd_t;

endpackage

[hw/rtl/cpf_ifs.sv]
// Interfaces: input request channel and result channel.
interface cpf_in_if
    import cpf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ID_W-1:0]   frame_id;
    logic [BYTE_W-1:0] payload_len;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output frame_id, output payload_len, output data_byte,
                    input ready);
    modport sink   (input valid, input frame_id, input payload_len, input data_byte,
                    output ready);
endinterface

interface cpf_out_if
    import cpf_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              frame_error;
    logic              frame_done;
    logic              last_of_run;

    modport source (output valid, output out_byte, output frame_error, output frame_done,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input frame_error, input frame_done,
                    input last_of_run, output ready);
endinterface

[hw/rtl/checksummed_packet_framer_top.sv]
// A request's first result goes through the queue entry, written at the accepting edge,
// then the output register; the back part loads one result a cycle unless held by ready.
// Throughput: one mid-frame request per cycle while the queue is not full. A frame start
// gives header, length, data (+checksum for 1-byte payload); a rejected start, one error.
// The command queue (QUEUE_DEPTH entries) absorbs frame starts so requests keep flowing.
// Reset (rst_n, async, active low): idle, empty queue, no result valid, header tag = 10.
module checksummed_packet_framer_top
    import cpf_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    cpf_in_if.sink           in_ch,
    cpf_out_if.source        out_ch,
    input  logic             cfg_we,
    input  logic [TAG_W-1:0] cfg_data
);

    // Front -> queue: one command per accepted request.
    logic q_full;
    logic q_push;
    cmd_t q_cmd;

    // Queue -> back: head command, popped once all its results are loaded.
    logic q_head_valid;
    cmd_t q_head_cmd;
    logic q_pop;

    // Front part: classifies each request (rejected start, frame start, mid-frame)
    // and keeps the byte count and running checksum.
    cpf_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_ch    (in_ch),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_cmd)
    );

    // Short queue decouples request acceptance from result emission.
    cpf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (q_cmd),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd)
    );

    // Back part: walks header, length, data and checksum, or a single error result, into the output register.
    cpf_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .pop        (q_pop),
        .out_ch     (out_ch)
    );

`ifndef SYNTHESIS
    // Rejected start is a single, empty, terminal result.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.frame_error |->
            out_ch.last_of_run && !out_ch.frame_done && (out_ch.out_byte == '0))
        else $error("error result malformed");

    // Checksum byte always closes the request's results.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid && out_ch.frame_done |-> out_ch.last_of_run && !out_ch.frame_error)
        else $error("checksum not last");

    // No command is written into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");

    // The back part only pops a command that is present.
    assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_head_valid)
        else $error("pop from empty queue");
`endif

endmodule

[hw/rtl/cpf_front.sv]
// Front part: accepts requests, tracks frame position and checksum, builds commands.
module cpf_front
    import cpf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    cpf_in_if.sink            in_ch,
    input  logic              cfg_we,
    input  logic [TAG_W-1:0]  cfg_data,
    input  logic              q_full,
    output logic              q_push,
    output cmd_t              q_cmd
);

    logic [TAG_W-1:0]  tag_reg;
    logic [BYTE_W-1:0] bytes_left_reg, bytes_left_next;
    logic [BYTE_W-1:0] sum_reg, sum_next;

    logic              idle;
    logic              bad;
    logic [BYTE_W-1:0] left_cur;
    logic [BYTE_W-1:0] left_after;
    logic [BYTE_W-1:0] sum_new;

    assign in_ch.ready = !q_full;
    assign q_push      = in_ch.valid && !q_full;

    always_comb
    begin
        idle       = (bytes_left_reg == '0);
        bad        = idle && ((in_ch.frame_id == ID_INVALID) || (in_ch.payload_len == '0)
                     || (in_ch.payload_len > MAX_PAYLOAD));
        left_cur   = idle ? in_ch.payload_len : bytes_left_reg;
        left_after = left_cur - 1'b1;
        sum_new    = (idle ? '0 : sum_reg) + in_ch.data_byte;

        q_cmd.kind    = bad ? CMD_ERROR : (idle ? CMD_START : CMD_MID);
        q_cmd.has_sum = (left_after == '0);
        q_cmd.header  = {tag_reg, in_ch.frame_id};
        q_cmd.len     = in_ch.payload_len;
        q_cmd.data    = in_ch.data_byte;
        q_cmd.sum     = sum_new;

        bytes_left_next = bytes_left_reg;
        sum_next        = sum_reg;
        if (q_push && !bad)
        begin
            bytes_left_next = left_after;
            sum_next        = (left_after == '0) ? '0 : sum_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg        <= TAG_RESET;
            bytes_left_reg <= '0;
            sum_reg        <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                tag_reg <= cfg_data;
            end
            bytes_left_reg <= bytes_left_next;
            sum_reg        <= sum_next;
        end
    end

endmodule

[hw/rtl/cpf_queue.sv]
// Command queue between front and back parts.
module cpf_queue
    import cpf_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output logic head_valid,
    output cmd_t head_cmd
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cmd_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem_reg[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hw/rtl/cpf_back.sv]
// Back part: expands each command into output bytes through a registered output stage.
module cpf_back
    import cpf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      head_valid,
    input  cmd_t      head_cmd,
    output logic      pop,
    cpf_out_if.source out_ch
);

    typedef enum logic [2:0] {
        PH_ERR,
        PH_HDR,
        PH_LEN,
        PH_DATA,
        PH_SUM
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic              in_cmd_reg, in_cmd_next;
    logic              valid_reg, valid_next;
    logic [BYTE_W-1:0] byte_reg, byte_next;
    logic              err_reg, err_next;
    logic              done_reg, done_next;
    logic              last_reg, last_next;

    phase_t            cur_phase;
    phase_t            after_phase;
    logic              cmd_end;
    logic              advance;
    logic [BYTE_W-1:0] res_byte;
    logic              res_err;
    logic              res_done;
    logic              res_last;

    assign advance = !valid_reg || out_ch.ready;
    assign pop     = advance && head_valid && cmd_end;

    always_comb
    begin
        if (in_cmd_reg)
        begin
            cur_phase = phase_reg;
        end
        else
        begin
            case (head_cmd.kind)
                CMD_ERROR: cur_phase = PH_ERR;
                CMD_START: cur_phase = PH_HDR;
                default:   cur_phase = PH_DATA;
            endcase
        end

        res_byte    = '0;
        res_err     = 1'b0;
        res_done    = 1'b0;
        res_last    = 1'b0;
        cmd_end     = 1'b0;
        after_phase = cur_phase;
        case (cur_phase)
            PH_ERR:
            begin
                res_err  = 1'b1;
                res_last = 1'b1;
                cmd_end  = 1'b1;
            end
            PH_HDR:
            begin
                res_byte    = head_cmd.header;
                after_phase = PH_LEN;
            end
            PH_LEN:
            begin
                res_byte    = head_cmd.len;
                after_phase = PH_DATA;
            end
            PH_DATA:
            begin
                res_byte    = head_cmd.data;
                res_last    = !head_cmd.has_sum;
                cmd_end     = !head_cmd.has_sum;
                after_phase = PH_SUM;
            end
            PH_SUM:
            begin
                res_byte = head_cmd.sum;
                res_done = 1'b1;
                res_last = 1'b1;
                cmd_end  = 1'b1;
            end
            default:
            begin
                cmd_end = 1'b1;
            end
        endcase

        phase_next  = phase_reg;
        in_cmd_next = in_cmd_reg;
        valid_next  = valid_reg;
        byte_next   = byte_reg;
        err_next    = err_reg;
        done_next   = done_reg;
        last_next   = last_reg;
        if (advance)
        begin
            valid_next = head_valid;
            if (head_valid)
            begin
                byte_next   = res_byte;
                err_next    = res_err;
                done_next   = res_done;
                last_next   = res_last;
                in_cmd_next = !cmd_end;
                phase_next  = after_phase;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_ERR;
            in_cmd_reg <= 1'b0;
            valid_reg  <= 1'b0;
            byte_reg   <= '0;
            err_reg    <= 1'b0;
            done_reg   <= 1'b0;
            last_reg   <= 1'b0;
        end
        else
        begin
            phase_reg  <= phase_next;
            in_cmd_reg <= in_cmd_next;
            valid_reg  <= valid_next;
            byte_reg   <= byte_next;
            err_reg    <= err_next;
            done_reg   <= done_next;
            last_reg   <= last_next;
        end
    end

    assign out_ch.valid       = valid_reg;
    assign out_ch.out_byte    = byte_reg;
    assign out_ch.frame_error = err_reg;
    assign out_ch.frame_done  = done_reg;
    assign out_ch.last_of_run = last_reg;

endmodule
